/* design/lidar_scan_packet_decoder_core_assert.svh */
// assertion macros shared by the decoder modules
`ifndef LIDAR_SCAN_PACKET_DECODER_CORE_ASSERT_SVH
`define LIDAR_SCAN_PACKET_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk and held off during reset
`define LSPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lspd assertion failed");

// next-cycle implication, checked on clk and held off during reset
`define LSPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lspd assertion failed");

`endif

/* design/lspd_pkg.sv */
// shared types and constants of the lidar scan packet decoder
package lspd_pkg;

	localparam int ANGLE_SLOTS = 360;
	localparam int ANGLE_W     = 9;
	localparam int RX_W        = 8;
	localparam int DIST_W      = 14;
	localparam int WIN_LEN     = 5;

	localparam logic [ANGLE_W:0]   SLOTS_X   = (ANGLE_W + 1)'(ANGLE_SLOTS);
	localparam logic [ANGLE_W-1:0] LAST_SLOT = ANGLE_W'(ANGLE_SLOTS - 1);

	typedef enum logic {
		OPC_BYTE = 1'b0,
		OPC_READ = 1'b1
	} opcode_t;

	typedef logic [WIN_LEN-1:0][RX_W-1:0] window_t;

	typedef struct packed {
		logic               hit;
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  distance;
	} dec_t;

	typedef struct packed {
		logic               point_valid;
		logic               is_read_reply;
		logic [ANGLE_W-1:0] point_angle;
		logic [DIST_W-1:0]  point_distance;
		logic               use_ram;
	} stage_t;

	typedef struct packed {
		logic               point_valid;
		logic               is_read_reply;
		logic [ANGLE_W-1:0] point_angle;
		logic [DIST_W-1:0]  point_distance;
	} resp_t;

endpackage

/* design/lspd_cmd_if.sv */
// input channel: link bytes and table read requests
interface lspd_cmd_if import lspd_pkg::*; ();
	logic               valid;
	logic               ready;
	opcode_t            opcode;
	logic [RX_W-1:0]    rx_byte;
	logic [ANGLE_W-1:0] read_angle;

	modport source(output valid, opcode, rx_byte, read_angle, input ready);
	modport sink(input valid, opcode, rx_byte, read_angle, output ready);
endinterface

/* design/lspd_res_if.sv */
// output channel: decoded points and read replies
interface lspd_res_if import lspd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               point_valid;
	logic               is_read_reply;
	logic [ANGLE_W-1:0] point_angle;
	logic [DIST_W-1:0]  point_distance;

	modport source(output valid, point_valid, is_read_reply, point_angle, point_distance,
		input ready);
	modport sink(input valid, point_valid, is_read_reply, point_angle, point_distance,
		output ready);
endinterface

/* design/lspd_ram.sv */
// generic simple dual-port ram with registered read
module lspd_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 360
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* design/lspd_decoder.sv */
// five-byte window, packet detection and angle / distance decode
module lspd_decoder import lspd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [RX_W-1:0] rx_byte,
	output dec_t            dec
);
	`include "lidar_scan_packet_decoder_core_assert.svh"

	window_t            win_q;
	window_t            win_nxt;
	logic [ANGLE_W-1:0] angle_raw;
	logic [ANGLE_W:0]   angle_sub;

	// oldest byte in slot 0, newest in the top slot
	always_comb begin
		win_nxt = {rx_byte, win_q[WIN_LEN-1:1]};
		angle_raw = {win_nxt[2], win_nxt[1][7]};
		angle_sub = {1'b0, angle_raw} - SLOTS_X;
		dec.hit = (win_nxt[0][0] != win_nxt[0][1]) && win_nxt[1][0];
		dec.angle = ({1'b0, angle_raw} >= SLOTS_X) ? angle_sub[ANGLE_W-1:0] : angle_raw;
		dec.distance = {win_nxt[4], win_nxt[3][RX_W-1:2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (accept) begin
			win_q <= dec.hit ? '0 : win_nxt;
		end
	end

	`LSPD_ASSERT_NEXT(a_win_cleared, accept && dec.hit, win_q == '0)
	`LSPD_ASSERT_NOW(a_angle_range, dec.hit, {1'b0, dec.angle} < SLOTS_X)
endmodule

/* design/lspd_resp.sv */
// result stage after the table read and the output register
module lspd_resp import lspd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  stage_t            stg,
	input  logic [DIST_W-1:0] rd_data,
	output logic              s1_free,
	lspd_res_if.source        res
);
	logic   v_s1_q;
	stage_t stg_s1;
	logic   v_s2_q;
	resp_t  rsp_s2;
	logic   adv;

	assign adv     = v_s1_q && (!v_s2_q || res.ready);
	assign s1_free = !v_s1_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			if (load) begin
				v_s1_q <= 1'b1;
			end else if (adv) begin
				v_s1_q <= 1'b0;
			end
			if (adv) begin
				v_s2_q <= 1'b1;
			end else if (res.ready) begin
				v_s2_q <= 1'b0;
			end
		end
	end

	// table read data is held by the ram until the next read
	always_ff @(posedge clk) begin
		if (load) begin
			stg_s1 <= stg;
		end
		if (adv) begin
			rsp_s2.point_valid    <= stg_s1.point_valid;
			rsp_s2.is_read_reply  <= stg_s1.is_read_reply;
			rsp_s2.point_angle    <= stg_s1.point_angle;
			rsp_s2.point_distance <= stg_s1.use_ram ? rd_data : stg_s1.point_distance;
		end
	end

	assign res.valid          = v_s2_q;
	assign res.point_valid    = rsp_s2.point_valid;
	assign res.is_read_reply  = rsp_s2.is_read_reply;
	assign res.point_angle    = rsp_s2.point_angle;
	assign res.point_distance = rsp_s2.point_distance;
endmodule

/* design/lidar_scan_packet_decoder_core.sv */
// Lidar scan packet decoder: takes one beat per cycle while cmd.ready is high, link
// bytes or table reads, and returns one result beat for each, in order, through the
// stage register and then the output register when the output is free. The distance
// table sits in one ram with a registered read; a packet writes it in its acceptance
// cycle and a read looks it up in its own, so a read beat right after a packet already
// sees the new entry. Up to two beats wait inside while the output stalls. After reset
// the block zeroes all 360 table entries, one entry a cycle, and holds cmd.ready low until that pass is done.
module lidar_scan_packet_decoder_core import lspd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lspd_cmd_if.sink   cmd,
	lspd_res_if.source res
);
	`include "lidar_scan_packet_decoder_core_assert.svh"

	logic               clr_active_q;
	logic [ANGLE_W-1:0] clr_cnt_q;
	logic               acc;
	logic               byte_acc;
	logic               rd_acc;
	logic               rd_in_range;
	logic               s1_free;
	dec_t               dec;
	stage_t             stg;
	logic               ram_we;
	logic [ANGLE_W-1:0] ram_waddr;
	logic [DIST_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [DIST_W-1:0]  ram_rdata;

	assign cmd.ready   = !clr_active_q && s1_free;
	assign acc         = cmd.valid && cmd.ready;
	assign byte_acc    = acc && (cmd.opcode == OPC_BYTE);
	assign rd_acc      = acc && (cmd.opcode == OPC_READ);
	assign rd_in_range = {1'b0, cmd.read_angle} < SLOTS_X;

	// table clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST_SLOT) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	lspd_decoder u_decoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (byte_acc),
		.rx_byte (cmd.rx_byte),
		.dec     (dec)
	);

	assign ram_we    = clr_active_q || (byte_acc && dec.hit);
	assign ram_waddr = clr_active_q ? clr_cnt_q : dec.angle;
	assign ram_wdata = clr_active_q ? '0 : dec.distance;
	assign ram_re    = rd_acc && rd_in_range;

	lspd_ram #(
		.WIDTH (DIST_W),
		.DEPTH (ANGLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cmd.read_angle),
		.rdata (ram_rdata)
	);

	always_comb begin
		stg.point_valid    = byte_acc && dec.hit;
		stg.is_read_reply  = (cmd.opcode == OPC_READ);
		stg.use_ram        = (cmd.opcode == OPC_READ) && rd_in_range;
		stg.point_angle    = '0;
		stg.point_distance = '0;
		if (cmd.opcode == OPC_READ) begin
			stg.point_angle = cmd.read_angle;
		end else if (dec.hit) begin
			stg.point_angle    = dec.angle;
			stg.point_distance = dec.distance;
		end
	end

	lspd_resp u_resp (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (acc),
		.stg     (stg),
		.rd_data (ram_rdata),
		.s1_free (s1_free),
		.res     (res)
	);

	`LSPD_ASSERT_NOW(a_no_beat_in_clear, clr_active_q, !cmd.ready)
	`LSPD_ASSERT_NOW(a_no_rw_overlap, ram_we, !ram_re)
	`LSPD_ASSERT_NOW(a_wr_in_range, ram_we, {1'b0, ram_waddr} < SLOTS_X)
endmodule
